FILE: hdl/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared constants, codes and saturation helpers of the vertex transform unit.
// ----------------------------------------------------------------------------
`default_nettype none
package vtp_pkg;

	localparam int VTP_FRAC_BITS = 16;

	// op codes (tuser of the input stream)
	localparam logic VTP_OP_LOAD  = 1'b0;
	localparam logic VTP_OP_XFORM = 1'b1;

	// register map
	localparam int          VTP_ADDR_W       = 3;
	localparam logic [2:0]  VTP_REG_PROJ_EN  = 3'd0;

	typedef struct packed {
		logic [31:0] v;
		logic        sat;
	} clip_t;

	// clip a signed value to the signed 32-bit range
	function automatic clip_t clip32(input logic signed [63:0] a);
		clip_t r;
		if (a > 64'sh0000_0000_7FFF_FFFF) begin
			r.v   = 32'h7FFF_FFFF;
			r.sat = 1'b1;
		end else if (a < -64'sh0000_0000_8000_0000) begin
			r.v   = 32'h8000_0000;
			r.sat = 1'b1;
		end else begin
			r.v   = a[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	// saturating add of two Q words
	function automatic clip_t sat_add(input logic [31:0] a, input logic [31:0] b);
		logic signed [63:0] s;
		s = 64'($signed(a)) + 64'($signed(b));
		return clip32(s);
	endfunction

endpackage
`default_nettype wire

FILE: hdl/vertex_transform_perspective_divide.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide
// 4x4 matrix times vertex in signed fixed point, optional divide by w.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  s_axis    in   tvalid/tready    tuser op; tdata row,col,coef,x,y,z,w
//  m_axis    out  tvalid/tready    tdata x,y,z,w; tuser was_divided,saturated
//  apb       in   psel/penable     project_enable at address 0
//
//  One word per cycle while m_axis accepts. A transform passes one multiply
//  stage, one shift/clip stage, three add stages, one pipelined divider
//  stage per quotient bit and the output register.
//  Load words update the matrix at accept and give no result. Each stage
//  fills whenever it is empty, so bubbles collapse under a stall at m_axis.
//  Reset: matrix is identity, project_enable is 1, pipeline empty.
// ----------------------------------------------------------------------------
`default_nettype none
module vertex_transform_perspective_divide
	import vtp_pkg::*;
#(
	parameter int FRAC_BITS = VTP_FRAC_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// row_sel[1:0], col_sel[3:2], coef_value[35:4], in_x[67:36],
	// in_y[99:68], in_z[131:100], in_w[163:132], zero pad [167:164]
	input  wire logic [167:0]          s_axis_tdata,
	// op[0]
	input  wire logic                  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
	output logic [127:0]               m_axis_tdata,
	// was_divided[0], saturated[1]
	output logic [1:0]                 m_axis_tuser,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [VTP_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int NW = 32 + FRAC_BITS;	// quotient bits

	typedef struct packed {
		logic [31:0]    rem;
		logic [NW-1:0]  num;
		logic [NW-1:0]  quo;
	} lane_t;

	typedef struct packed {
		lane_t [2:0]       ln;
		logic  [2:0]       neg;
		logic  [31:0]      dvs;
		logic  [3:0][31:0] res;
		logic              dv;
		logic              sat;
	} dstage_t;

	function automatic dstage_t div_step(input dstage_t a);
		dstage_t     r;
		logic [32:0] tr;
		r = a;
		for (int l = 0; l < 3; l++) begin
			tr = {a.ln[l].rem, a.ln[l].num[NW-1]};
			r.ln[l].num = a.ln[l].num << 1;
			if (tr >= {1'b0, a.dvs}) begin
				tr = tr - {1'b0, a.dvs};
				r.ln[l].quo = {a.ln[l].quo[NW-2:0], 1'b1};
			end else begin
				r.ln[l].quo = {a.ln[l].quo[NW-2:0], 1'b0};
			end
			r.ln[l].rem = tr[31:0];
		end
		return r;
	endfunction

	// ---------------- configuration ----------------
	logic proj_en_q;
	logic cfg_wr;
	logic cfg_sel;

	// word decode, byte offset ignored
	assign cfg_sel = (paddr[VTP_ADDR_W-1:2] == VTP_REG_PROJ_EN[VTP_ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = cfg_sel ? {31'b0, proj_en_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj_en_q <= 1'b1;
		end else if (cfg_wr && cfg_sel) begin
			proj_en_q <= pwdata[0];
		end
	end

	// ---------------- input unpack, matrix ----------------
	logic [1:0]        in_row, in_col;
	logic [31:0]       in_coef;
	logic [3:0][31:0]  in_vec;
	logic              in_acc;

	assign in_row    = s_axis_tdata[1:0];
	assign in_col    = s_axis_tdata[3:2];
	assign in_coef   = s_axis_tdata[35:4];
	assign in_vec[0] = s_axis_tdata[67:36];
	assign in_vec[1] = s_axis_tdata[99:68];
	assign in_vec[2] = s_axis_tdata[131:100];
	assign in_vec[3] = s_axis_tdata[163:132];
	assign in_acc    = s_axis_tvalid && s_axis_tready;

	logic [3:0][3:0][31:0] mat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					mat_q[r][c] <= (r == c) ? (32'd1 << FRAC_BITS) : 32'd0;
				end
			end
		end else if (in_acc && s_axis_tuser == VTP_OP_LOAD) begin
			mat_q[in_row][in_col] <= in_coef;
		end
	end

	// ---------------- stage control ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [NW-1:0] v_div;
	logic out_v_q;
	logic adv1, adv2, adv3, adv4, adv5, adv_out;
	logic [NW-1:0] adv_div;

	assign adv_out = !out_v_q || m_axis_tready;
	always_comb begin
		adv_div[NW-1] = !v_div[NW-1] || adv_out;
		for (int i = NW - 2; i >= 0; i--) begin
			adv_div[i] = !v_div[i] || adv_div[i+1];
		end
	end
	assign adv5 = !v_s5 || adv_div[0];
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_div   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_acc && s_axis_tuser == VTP_OP_XFORM;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv_div[0]) v_div[0] <= v_s5;
			for (int i = 1; i < NW; i++) begin
				if (adv_div[i]) v_div[i] <= v_div[i-1];
			end
			if (adv_out) out_v_q <= v_div[NW-1];
		end
	end

	// ---------------- s1: products ----------------
	logic [3:0][3:0][63:0] prod_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s1[r][c] <= $signed(mat_q[r][c]) * $signed(in_vec[c]);
				end
			end
		end
	end

	// ---------------- s2: floor shift and clip ----------------
	logic [3:0][3:0][31:0] term_s2;
	logic                  sat_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			logic  sat;
			clip_t cl;
			sat = 1'b0;
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					cl = clip32($signed(prod_s1[r][c]) >>> FRAC_BITS);
					term_s2[r][c] <= cl.v;
					sat = sat | cl.sat;
				end
			end
			sat_s2 <= sat;
		end
	end

	// ---------------- s3..s5: running sums in column order ----------------
	logic [3:0][31:0]      acc_s3, acc_s4, acc_s5;
	logic [3:0][1:0][31:0] rest_s3;
	logic [3:0][31:0]      rest_s4;
	logic                  sat_s3, sat_s4, sat_s5;

	always_ff @(posedge clk) begin
		if (adv3) begin
			logic  sat;
			clip_t cl;
			sat = sat_s2;
			for (int r = 0; r < 4; r++) begin
				cl = sat_add(term_s2[r][0], term_s2[r][1]);
				acc_s3[r]     <= cl.v;
				rest_s3[r][0] <= term_s2[r][2];
				rest_s3[r][1] <= term_s2[r][3];
				sat = sat | cl.sat;
			end
			sat_s3 <= sat;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			logic  sat;
			clip_t cl;
			sat = sat_s3;
			for (int r = 0; r < 4; r++) begin
				cl = sat_add(acc_s3[r], rest_s3[r][0]);
				acc_s4[r]  <= cl.v;
				rest_s4[r] <= rest_s3[r][1];
				sat = sat | cl.sat;
			end
			sat_s4 <= sat;
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			logic  sat;
			clip_t cl;
			sat = sat_s4;
			for (int r = 0; r < 4; r++) begin
				cl = sat_add(acc_s4[r], rest_s4[r]);
				acc_s5[r] <= cl.v;
				sat = sat | cl.sat;
			end
			sat_s5 <= sat;
		end
	end

	// ---------------- divider: one quotient bit per stage ----------------
	dstage_t div_init;
	dstage_t div_s [NW];

	always_comb begin
		logic [31:0] mag;
		div_init.res = acc_s5;
		div_init.sat = sat_s5;
		div_init.dv  = proj_en_q && (acc_s5[3] != 32'd0);
		div_init.dvs = acc_s5[3][31] ? (32'd0 - acc_s5[3]) : acc_s5[3];
		for (int l = 0; l < 3; l++) begin
			mag = acc_s5[l][31] ? (32'd0 - acc_s5[l]) : acc_s5[l];
			div_init.neg[l]    = acc_s5[l][31] ^ acc_s5[3][31];
			div_init.ln[l].rem = 32'd0;
			div_init.ln[l].num = {mag, {FRAC_BITS{1'b0}}};
			div_init.ln[l].quo = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_div[0]) div_s[0] <= div_step(div_init);
		for (int i = 1; i < NW; i++) begin
			if (adv_div[i]) div_s[i] <= div_step(div_s[i-1]);
		end
	end

	// ---------------- output register ----------------
	logic [3:0][31:0] res_q;
	logic             dv_q, sat_q;

	always_ff @(posedge clk) begin
		if (adv_out) begin
			logic               sat;
			logic signed [63:0] sq;
			clip_t              cl;
			sat = div_s[NW-1].sat;
			for (int l = 0; l < 3; l++) begin
				sq = $signed(64'(div_s[NW-1].ln[l].quo));
				if (div_s[NW-1].neg[l]) sq = -sq;
				cl = clip32(sq);
				if (div_s[NW-1].dv) begin
					res_q[l] <= cl.v;
					sat = sat | cl.sat;
				end else begin
					res_q[l] <= div_s[NW-1].res[l];
				end
			end
			res_q[3] <= div_s[NW-1].res[3];
			dv_q     <= div_s[NW-1].dv;
			sat_q    <= sat;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {res_q[3], res_q[2], res_q[1], res_q[0]};
	assign m_axis_tuser  = {sat_q, dv_q};

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Vertex transform testbench
// Streams matrix loads and vertex transforms through the unit with random
// idling on both sides, predicts each result in a fixed-point model of its
// own and compares every output word field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class xform_scoreboard;
	logic signed [31:0] coefs [16];
	logic               proj_en;
	logic [129:0]       pending [$];
	int                 errors;

	function void reset_state();
		for (int i = 0; i < 16; i++)
			coefs[i] = ((i & 3) == (i >> 2)) ? 32'sd1 <<< vtp_pkg::VTP_FRAC_BITS : 32'sd0;
		proj_en = 1'b1;
		pending.delete();
		errors = 0;
	endfunction

	function logic signed [31:0] clip(input logic signed [63:0] a, inout logic sat);
		if (a > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (a < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'sh8000_0000;
		end
		return a[31:0];
	endfunction

	// note an accepted input word
	function void note_input(input logic op, input logic [167:0] d);
		logic signed [31:0] vec [4];
		logic signed [31:0] res [4];
		logic signed [31:0] acc, term, w;
		logic signed [63:0] p, num;
		logic sat, dv;
		sat = 1'b0;
		dv = 1'b0;
		if (op == vtp_pkg::VTP_OP_LOAD) begin
			coefs[{d[1:0], d[3:2]}] = d[35:4];
			return;
		end
		for (int c = 0; c < 4; c++)
			vec[c] = d[36 + 32*c +: 32];
		for (int r = 0; r < 4; r++) begin
			acc = 32'sd0;
			for (int c = 0; c < 4; c++) begin
				p = 64'(coefs[r*4 + c]) * 64'(vec[c]);
				term = clip(p >>> vtp_pkg::VTP_FRAC_BITS, sat);
				acc = clip(64'(acc) + 64'(term), sat);
			end
			res[r] = acc;
		end
		if (proj_en && res[3] != 0) begin
			dv = 1'b1;
			w = res[3];
			for (int r = 0; r < 3; r++) begin
				num = 64'(res[r]) <<< vtp_pkg::VTP_FRAC_BITS;
				res[r] = clip(num / 64'(w), sat);
			end
		end
		pending.push_back({sat, dv, res[3], res[2], res[1], res[0]});
	endfunction

	function void report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		errors++;
	endfunction

	function void check_result(input logic [127:0] d, input logic [1:0] u);
		logic [129:0] e;
		if (pending.size() == 0) begin
			$display("unexpected output word at %0t", $time);
			errors++;
			return;
		end
		e = pending.pop_front();
		for (int i = 0; i < 4; i++)
			if (d[32*i +: 32] !== e[32*i +: 32])
				report($sformatf("component %0d", i), d[32*i +: 32], e[32*i +: 32]);
		if (u[0] !== e[128]) report("was_divided", 32'(u[0]), 32'(e[128]));
		if (u[1] !== e[129]) report("saturated", 32'(u[1]), 32'(e[129]));
	endfunction
endclass

module testbench;
	import vtp_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [167:0]          s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [127:0]          m_axis_tdata;
	logic [1:0]            m_axis_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [VTP_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	xform_scoreboard sb = new();
	int  src_idle_pct = 31;
	int  snk_idle_pct = 31;
	int  holdoff = 0;
	int  quiet_cycles = 0;

	localparam int WATCHDOG = 20000;
	localparam int LATENCY = 38 + VTP_FRAC_BITS;

	vertex_transform_perspective_divide u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
		if (holdoff > 0) begin
			holdoff <= holdoff - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// tvalid stays up after an accept; the next word or drain() sets it
	task automatic send_word(input logic op, input logic [167:0] d);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(op, d);
	endtask

	task automatic load_coef(input logic [1:0] r, input logic [1:0] c, input logic [31:0] v);
		send_word(VTP_OP_LOAD, {4'b0, $urandom(), $urandom(), $urandom(), $urandom(), v, c, r});
	endtask

	task automatic xform(input logic [31:0] x, y, z, w);
		send_word(VTP_OP_XFORM, {4'b0, w, z, y, x, $urandom(), 4'($urandom())});
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_proj(input logic en);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= VTP_REG_PROJ_EN;
		pwdata <= {$urandom_range(1) ? 31'($urandom()) : 31'b0, en};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.proj_en = en;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [31:0] rand_val(input int kind);
		case (kind)
			0: return $urandom();
			1: return 32'($signed($urandom_range(4096))) - 32'sd2048 <<< 8;
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(8 << 16))) - 32'sd4 * 32'sd65536;
		endcase
	endfunction

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 20)
				load_coef(2'($urandom()), 2'($urandom()), rand_val($urandom_range(3)));
			else if ($urandom_range(99) < 5)
				xform(rand_val(3), rand_val(3), rand_val(3), 32'h0);
			else
				xform(rand_val($urandom_range(3)), rand_val($urandom_range(3)),
					rand_val($urandom_range(3)), rand_val($urandom_range(3)));
		end
	endtask

	initial begin
		sb.reset_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity matrix, extremes, zero w
		xform(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
		xform(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
		xform(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
		xform(32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
		xform(32'h0, 32'h0, 32'h0, 32'h8000_0000);
		load_coef(2'd0, 2'd0, 32'h7FFF_FFFF);
		load_coef(2'd3, 2'd3, 32'h8000_0000);
		load_coef(2'd0, 2'd3, 32'h7FFF_FFFF);
		load_coef(2'd3, 2'd0, 32'hFFFF_FFFF);
		xform(32'h7FFF_FFFF, 32'h1, 32'h1, 32'h7FFF_FFFF);
		xform(32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000);
		xform(32'h0001_0000, 32'h0, 32'h0, 32'h0);
		drain();
		write_proj(1'b0);
		xform(32'h7FFF_FFFF, 32'h1, 32'h1, 32'h7FFF_FFFF);
		xform(32'h0003_0000, 32'h0, 32'h0, 32'h0002_0000);

		random_phase(300);
		drain();
		write_proj(1'b1);

		// long receiver hold-off while the sender keeps offering
		holdoff = 400;
		random_phase(150);

		// stretch with no idling
		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_phase(300);
		src_idle_pct = 31;
		snk_idle_pct = 31;
		drain();
		write_proj(1'b0);
		random_phase(300);
		drain();
		write_proj(1'b1);
		random_phase(450);

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

`default_nettype wire
